@@ rtl/bdsci_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bdsci_pkg;

   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int MAX_EMBED_DEF   = 8;

   localparam int SAMPLE_W = 32;
   localparam int THR_W    = 32;
   localparam int DIM_W    = 4;
   localparam int PAIR_W   = 19;
   localparam int SQ_W     = 31;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVFL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EMBED      = 4'd1;

   typedef struct packed {
      logic valid;
      logic diag;
      logic same;
      logic lower;
      logic row_end;
      logic first;
   } pair_tag_type;

endpackage
`default_nettype wire

@@ rtl/bdsci_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bdsci_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule
`default_nettype wire

@@ rtl/bdsci_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bdsci_accum
   import bdsci_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int MAX_EMBED   = MAX_EMBED_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire logic [THR_W-1:0]    near_threshold,
   input  wire pair_tag_type        tag,
   input  wire logic [SAMPLE_W-1:0] data_a,
   input  wire logic [SAMPLE_W-1:0] data_b,
   output logic      [PAIR_W-1:0]   pairs_one,
   output logic      [SQ_W-1:0]     square_sum,
   output logic      [PAIR_W-1:0]   lane_pairs [MAX_EMBED-1]
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int PW = 2 * CW;
   localparam int RW = $clog2(MAX_EMBED + 1);

   logic signed [SAMPLE_W:0] diff_ab_ff, diff_ba_ff;
   pair_tag_type             tag_ff;
   logic [CW-1:0]            cnt_ff, cnt_in, cnt_nx;
   logic [RW-1:0]            run_ff, run_in;
   logic [PW-1:0]            sqterm_ff, sqterm_in;
   logic                     sqv_ff, sqv_in;
   logic [PAIR_W-1:0]        pairs_ff, pairs_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [PAIR_W-1:0]        lane_ff [MAX_EMBED-1];
   logic [PAIR_W-1:0]        lane_in [MAX_EMBED-1];
   logic [PW+SQ_W-1:0]       sqterm_wide;
   logic                     near, near_ab, near_ba;

   always_comb begin
      near_ab = diff_ab_ff[SAMPLE_W] || (diff_ab_ff[SAMPLE_W-1:0] < near_threshold);
      near_ba = diff_ba_ff[SAMPLE_W] || (diff_ba_ff[SAMPLE_W-1:0] < near_threshold);
      near    = tag_ff.same || (near_ab && near_ba);
      cnt_nx  = cnt_ff + CW'(near);
      sqterm_wide = {{SQ_W{1'b0}}, sqterm_ff};

      cnt_in    = cnt_ff;
      run_in    = run_ff;
      sqterm_in = sqterm_ff;
      sqv_in    = 1'b0;
      pairs_in  = pairs_ff;
      sq_in     = sq_ff;
      lane_in   = lane_ff;

      if (sqv_ff) begin
         sq_in = sq_ff + sqterm_wide[SQ_W-1:0];
      end
      if (tag_ff.valid && !tag_ff.diag) begin
         if (near && tag_ff.lower) begin
            pairs_in = pairs_ff + PAIR_W'(1);
         end
         if (tag_ff.row_end) begin
            sqterm_in = PW'(cnt_nx) * PW'(cnt_nx);
            sqv_in    = 1'b1;
            cnt_in    = '0;
         end else begin
            cnt_in = cnt_nx;
         end
      end
      if (tag_ff.valid && tag_ff.diag) begin
         if (!near) begin
            run_in = '0;
         end else if (tag_ff.first) begin
            run_in = RW'(1);
         end else if (run_ff == RW'(MAX_EMBED)) begin
            run_in = run_ff;
         end else begin
            run_in = run_ff + RW'(1);
         end
         for (int l = 0; l < MAX_EMBED - 1; l++) begin
            if (32'(run_in) >= l + 2) begin
               lane_in[l] = lane_ff[l] + PAIR_W'(1);
            end
         end
      end
      if (clear) begin
         cnt_in   = '0;
         run_in   = '0;
         sqv_in   = 1'b0;
         pairs_in = '0;
         sq_in    = '0;
         for (int l = 0; l < MAX_EMBED - 1; l++) begin
            lane_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      diff_ab_ff <= {data_a[SAMPLE_W-1], data_a} - {data_b[SAMPLE_W-1], data_b};
      diff_ba_ff <= {data_b[SAMPLE_W-1], data_b} - {data_a[SAMPLE_W-1], data_a};
      sqterm_ff  <= sqterm_in;
      if (reset) begin
         tag_ff   <= '0;
         cnt_ff   <= '0;
         run_ff   <= '0;
         sqv_ff   <= 1'b0;
         pairs_ff <= '0;
         sq_ff    <= '0;
         for (int l = 0; l < MAX_EMBED - 1; l++) begin
            lane_ff[l] <= '0;
         end
      end else begin
         tag_ff   <= tag;
         cnt_ff   <= cnt_in;
         run_ff   <= run_in;
         sqv_ff   <= sqv_in;
         pairs_ff <= pairs_in;
         sq_ff    <= sq_in;
         lane_ff  <= lane_in;
      end
   end

   assign pairs_one  = pairs_ff;
   assign square_sum = sq_ff;
   assign lane_pairs = lane_ff;

endmodule
`default_nettype wire

@@ rtl/bds_correlation_integral_counter_unit.sv @@
// a sample without the last mark is stored while room is left, no result; a run too short
// or too long gets one status result, any other is compared row by row, then along the
// diagonals, one pair compare per cycle through the dual-read sample memory
// throughput: 1 sample per cycle while loading; results leave 1 per cycle unless stalled
// reset: synchronous active-high; clears counters, flags, threshold; max embed 2; store kept
`timescale 1ns / 1ps
`default_nettype none
module bds_correlation_integral_counter_unit
   import bdsci_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int MAX_EMBED   = MAX_EMBED_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,   // sample[31:0]
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [55:0]          rsp_tdata,   // embed_dim, pair_count, square_sum, status
   output logic                      rsp_tlast,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = $clog2(MAX_SAMPLES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROWS  = 3'd1;
   localparam logic [2:0] S_DIAG  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       total_ff, total_in, i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic                ovf_ff, ovf_in;
   logic [2:0]          drain_ff, drain_in;
   logic [DIM_W-1:0]    idx_ff, idx_in, me_ff, me_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic [DIM_W-1:0]    cfg_me_ff, cfg_me_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [55:0]         rsp_data_ff, rsp_data_in;
   pair_tag_type        tag, tag_ff;

   logic                wr_en, acc_clear, accept, room, ovf_nx;
   logic [CW-1:0]       total_nx, nm1, ij_sum;
   logic [DIM_W-1:0]    me_eff;
   logic [AW-1:0]       rd_addr_a, rd_addr_b;
   logic [SAMPLE_W-1:0] data_a, data_b;
   logic [PAIR_W-1:0]   pairs_one, pick_pairs;
   logic [SQ_W-1:0]     square_sum;
   logic [PAIR_W-1:0]   lane_pairs [MAX_EMBED-1];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign room       = (32'(total_ff) < MAX_SAMPLES);
   assign total_nx   = room ? total_ff + CW'(1) : total_ff;
   assign ovf_nx     = ovf_ff || !room;
   assign nm1        = n_ff - CW'(1);
   assign ij_sum     = i_ff + j_ff;

   always_comb begin
      if (cfg_me_ff < DIM_W'(2)) begin
         me_eff = DIM_W'(2);
      end else if (32'(cfg_me_ff) > MAX_EMBED) begin
         me_eff = DIM_W'(MAX_EMBED);
      end else begin
         me_eff = cfg_me_ff;
      end
   end

   always_comb begin
      thr_in    = thr_ff;
      cfg_me_in = cfg_me_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NEAR_THRESHOLD: thr_in    = csr_data;
            CSR_MAX_EMBED:      cfg_me_in = csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pick_pairs = pairs_one;
      for (int l = 0; l < MAX_EMBED - 1; l++) begin
         if (32'(idx_ff) == l + 2) begin
            pick_pairs = lane_pairs[l];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      drain_in     = drain_ff;
      idx_in       = idx_ff;
      me_in        = me_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      acc_clear    = 1'b0;
      tag          = '0;
      rd_addr_a    = i_ff[AW-1:0];
      rd_addr_b    = j_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wr_en    = room;
               total_in = total_nx;
               ovf_in   = ovf_nx;
               if (req_tlast) begin
                  total_in = '0;
                  ovf_in   = 1'b0;
                  me_in    = me_eff;
                  n_in     = total_nx;
                  idx_in   = DIM_W'(1);
                  if (ovf_nx) begin
                     status_in = STAT_OVFL;
                     state_in  = S_EMIT;
                  end else if (32'(total_nx) <= 32'(me_eff)) begin
                     status_in = STAT_SHORT;
                     state_in  = S_EMIT;
                  end else begin
                     status_in = STAT_OK;
                     acc_clear = 1'b1;
                     i_in      = '0;
                     j_in      = '0;
                     state_in  = S_ROWS;
                  end
               end
            end
         end
         S_ROWS: begin
            tag.valid   = 1'b1;
            tag.same    = (i_ff == j_ff);
            tag.lower   = (j_ff < i_ff);
            tag.row_end = (j_ff == nm1);
            if (j_ff == nm1) begin
               j_in = '0;
               if (i_ff == nm1) begin
                  i_in     = '0;
                  j_in     = CW'(1);
                  state_in = S_DIAG;
               end else begin
                  i_in = i_ff + CW'(1);
               end
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         S_DIAG: begin
            rd_addr_b  = ij_sum[AW-1:0];
            tag.valid  = 1'b1;
            tag.diag   = 1'b1;
            tag.first  = (i_ff == '0);
            if (ij_sum == nm1) begin
               i_in = '0;
               if (j_ff == nm1) begin
                  drain_in = '0;
                  state_in = S_DRAIN;
               end else begin
                  j_in = j_ff + CW'(1);
               end
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff + 3'd1;
            if (drain_ff == 3'd3) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (status_ff != STAT_OK) begin
                  rsp_data_in = {status_ff, SQ_W'(0), PAIR_W'(0), DIM_W'(1)};
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  rsp_data_in = {STAT_OK,
                                 (idx_ff == DIM_W'(1)) ? square_sum : SQ_W'(0),
                                 pick_pairs, idx_ff};
                  rsp_last_in = (idx_ff == me_ff);
                  if (idx_ff == me_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in = idx_ff + DIM_W'(1);
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      n_ff        <= n_in;
      drain_ff    <= drain_in;
      idx_ff      <= idx_in;
      me_ff       <= me_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         thr_ff       <= '0;
         cfg_me_ff    <= DIM_W'(2);
         rsp_valid_ff <= 1'b0;
         tag_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         thr_ff       <= thr_in;
         cfg_me_ff    <= cfg_me_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= tag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   bdsci_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(MAX_SAMPLES)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (total_ff[AW-1:0]),
      .wr_data  (req_tdata),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(data_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(data_b)
   );

   bdsci_accum #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .MAX_EMBED  (MAX_EMBED)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .clear         (acc_clear),
      .near_threshold(thr_ff),
      .tag           (tag_ff),
      .data_a        (data_a),
      .data_b        (data_b),
      .pairs_one     (pairs_one),
      .square_sum    (square_sum),
      .lane_pairs    (lane_pairs)
   );

endmodule
`default_nettype wire

@@ rtl/bdsci_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bdsci_check
   import bdsci_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 req_tlast,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [55:0]          rsp_tdata,
   input wire logic                 rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

   a_fault_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[55:54] != STAT_OK |->
         rsp_tlast && rsp_tdata[3:0] == 4'd1 && rsp_tdata[53:4] == '0)
      else $error("fault result malformed");

   a_dim_one_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[55:54] == STAT_OK && rsp_tdata[3:0] == 4'd1 |-> !rsp_tlast)
      else $error("run ended at dimension one");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("sample transfer during computation");

endmodule

bind bds_correlation_integral_counter_unit bdsci_check u_check (.*);
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import bdsci_pkg::*;

   typedef struct {
      logic [DIM_W-1:0]  dim;
      logic [PAIR_W-1:0] pairs;
      logic [SQ_W-1:0]   sq;
      logic [STAT_W-1:0] stat;
      logic              last;
   } count_rec_type;

   class corr_scoreboard;
      logic signed [31:0] series[$];
      bit                 ovf;
      logic [31:0]        thr;
      logic [3:0]         embed_reg;
      count_rec_type      counts_due[$];
      int                 errors;

      function new();
         thr = 0;
         embed_reg = 2;
         ovf = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
         if (idx == CSR_NEAR_THRESHOLD) thr = v;
         else if (idx == CSR_MAX_EMBED) embed_reg = v[3:0];
      endfunction

      function bit is_close(int a, int b);
         longint d;
         if (a == b) return 1;
         d = longint'(series[a]) - longint'(series[b]);
         if (d < 0) d = -d;
         return d < longint'(thr);
      endfunction

      function void note_sample(logic [31:0] d, bit last);
         int n, me, cnt, k, nm1;
         longint pairs, sq;
         count_rec_type r;
         if (series.size() < MAX_SAMPLES_DEF) series.push_back(d);
         else ovf = 1;
         if (!last) return;
         n = series.size();
         me = embed_reg;
         if (me < 2) me = 2;
         if (me > MAX_EMBED_DEF) me = MAX_EMBED_DEF;
         if (ovf || n <= me) begin
            r.dim = 1; r.pairs = 0; r.sq = 0; r.last = 1;
            r.stat = ovf ? STAT_OVFL : STAT_SHORT;
            counts_due.push_back(r);
         end else begin
            pairs = 0;
            sq = 0;
            for (int i = 0; i < n; i++) begin
               cnt = 0;
               for (int j = 0; j < n; j++)
                  if (is_close(i, j)) begin
                     cnt++;
                     if (j < i) pairs++;
                  end
               sq += longint'(cnt) * cnt;
            end
            r.dim = 1; r.pairs = PAIR_W'(pairs); r.sq = SQ_W'(sq);
            r.stat = STAT_OK; r.last = 0;
            counts_due.push_back(r);
            for (int m = 2; m <= me; m++) begin
               nm1 = n - m + 1;
               pairs = 0;
               for (int s = 0; s < nm1; s++)
                  for (int t = s + 1; t < nm1; t++) begin
                     for (k = 0; k < m && is_close(s + k, t + k); k++) ;
                     if (k == m) pairs++;
                  end
               r.dim = DIM_W'(m); r.pairs = PAIR_W'(pairs); r.sq = 0;
               r.stat = STAT_OK; r.last = (m == me);
               counts_due.push_back(r);
            end
         end
         series.delete();
         ovf = 0;
      endfunction

      function void check(logic [55:0] data, logic last);
         count_rec_type w;
         if (counts_due.size() == 0) begin
            $error("unexpected result transfer %h", data);
            errors++;
            return;
         end
         w = counts_due.pop_front();
         if (data[3:0] !== w.dim) begin
            $error("embed_dim expected %0d got %0d", w.dim, data[3:0]); errors++;
         end
         if (data[22:4] !== w.pairs) begin
            $error("pair_count expected %0d got %0d", w.pairs, data[22:4]); errors++;
         end
         if (data[53:23] !== w.sq) begin
            $error("square_sum expected %0d got %0d", w.sq, data[53:23]); errors++;
         end
         if (data[55:54] !== w.stat) begin
            $error("status expected %0d got %0d", w.stat, data[55:54]); errors++;
         end
         if (last !== w.last) begin
            $error("last_result expected %0d got %0d", w.last, last); errors++;
         end
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_tvalid = 0;
   logic                 req_tready;
   logic [31:0]          req_tdata = 0;
   logic                 req_tlast = 0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 0;
   logic [55:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [31:0]          csr_data = 0;

   corr_scoreboard sb = new();
   bit   calm = 0;
   int   cycles = 0;
   int   sent = 0;

   bds_correlation_integral_counter_unit uut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tlast);
      rsp_tready <= calm || ($urandom_range(99) >= 32);
   end

   task automatic push_sample(logic [31:0] d, bit last);
      while (!calm && $urandom_range(99) < 32) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(d, last);
      sent++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.counts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(int mode, logic [31:0] base);
      case (mode)
         0: return base + $urandom_range(40) - 20;
         1: return $urandom;
         default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                           : 32'h80000000 + $urandom_range(3);
      endcase
   endfunction

   task automatic random_series(int n);
      int          mode;
      logic [31:0] base;
      mode = $urandom_range(9) < 7 ? 0 : $urandom_range(1, 2);
      base = $urandom;
      for (int i = 0; i < n; i++) push_sample(pick_value(mode, base), i == n - 1);
   endtask

   initial begin
      logic [31:0] thr;
      int          me, n;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes, zero threshold, default embedding
      push_sample(32'h7fffffff, 0);
      push_sample(32'h80000000, 0);
      push_sample(32'h00000000, 0);
      push_sample(32'hffffffff, 1);
      push_sample(32'h5, 1);
      push_sample(32'h5, 0);
      push_sample(32'h5, 1);
      drain();
      write_reg(CSR_NEAR_THRESHOLD, 32'hffffffff);
      write_reg(CSR_MAX_EMBED, 8);
      for (int i = 0; i < 9; i++) push_sample(i[0] ? 32'h7fffffff : 32'h80000000, i == 8);
      push_sample(32'h7fffffff, 0);
      push_sample(32'h80000001, 0);
      push_sample(32'h0, 1);
      drain();
      write_reg(CSR_MAX_EMBED, 0);
      write_reg(CSR_NEAR_THRESHOLD, 1);
      for (int i = 0; i < 4; i++) push_sample(i / 2, i == 3);
      drain();
      write_reg(CSR_MAX_EMBED, 15);

      // store overflow
      calm = 1;
      for (int i = 0; i < MAX_SAMPLES_DEF + 2; i++)
         push_sample($urandom, i == MAX_SAMPLES_DEF + 1);
      drain();
      calm = 0;

      for (int phase = 0; sent < MAX_SAMPLES_DEF + 30 + 310; phase++) begin
         case (phase % 6)
            0: thr = 0;
            1: thr = 32'hffffffff;
            2: thr = $urandom;
            default: thr = $urandom_range(30, 1);
         endcase
         me = (phase % 5 == 0) ? (phase[1] ? 0 : 15) : $urandom_range(8, 2);
         write_reg(CSR_NEAR_THRESHOLD, thr);
         write_reg(CSR_MAX_EMBED, me);
         calm = (phase == 3);
         if (me < 2) me = 2;
         if (me > 8) me = 8;
         for (int s = 0; s < 4; s++) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(me, 1) : $urandom_range(me + 12, me + 1);
            random_series(n);
         end
         drain();
      end

      calm = 0;
      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.counts_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

@@ files.f @@
rtl/bdsci_pkg.sv
rtl/bdsci_ram.sv
rtl/bdsci_accum.sv
rtl/bds_correlation_integral_counter_unit.sv
rtl/bdsci_check.sv
sim/testbench.sv
